// ----- hdl/fcc_pkg.sv -----
// ---------------------------------------------------------------------------
// fcc_pkg
// Shared widths, the item payload carried along the cell chain, the
// visibility codes and the final classification.
// ---------------------------------------------------------------------------
package fcc_pkg;

    localparam int COORD_BITS = 16;
    localparam int HALF_BITS  = COORD_BITS - 1;
    localparam int COEF_BITS  = 16;
    localparam int NUM_PLANES = 6;
    localparam int PLANE_BITS = 64;
    localparam int IDX_BITS   = 3;
    localparam int ADDR_BITS  = 6;
    localparam int PROD_BITS  = COEF_BITS + COORD_BITS;
    localparam int ACC_BITS   = PROD_BITS + 6;
    localparam int D_SHIFT    = COEF_BITS - 2;

    typedef logic [1:0] vis_t;

    localparam vis_t VIS_OUTSIDE = 2'd0;
    localparam vis_t VIS_PARTIAL = 2'd1;
    localparam vis_t VIS_INSIDE  = 2'd2;
    localparam vis_t VIS_UNUSED  = 2'd3;

    typedef logic [IDX_BITS-1:0] reg_idx_t;

    localparam reg_idx_t LAST_PLANE_IDX = reg_idx_t'(NUM_PLANES - 1);

    // item as it travels down the chain, with the verdict so far
    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic        [HALF_BITS-1:0]  hs;
        logic                         outside;
        logic                         all_front;
    } cube_t;

    function automatic vis_t classify(input logic outside, input logic all_front);
        vis_t v;
        if (outside)
        begin
            v = VIS_OUTSIDE;
        end
        else if (all_front)
        begin
            v = VIS_INSIDE;
        end
        else
        begin
            v = VIS_PARTIAL;
        end
        return v;
    endfunction

endpackage

// ----- hdl/fcc_regs.sv -----
// ---------------------------------------------------------------------------
// fcc_regs
// APB register file holding the six frustum planes, 64 bits each.
// ---------------------------------------------------------------------------
module fcc_regs
    import fcc_pkg::*;
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  psel,
    input  logic                                  penable,
    input  logic                                  pwrite,
    input  logic [ADDR_BITS-1:0]                  paddr,
    input  logic [PLANE_BITS-1:0]                 pwdata,
    output logic [PLANE_BITS-1:0]                 prdata,
    output logic                                  pready,
    output logic [NUM_PLANES-1:0][PLANE_BITS-1:0] planes
);

    logic [NUM_PLANES-1:0][PLANE_BITS-1:0] plane_reg;
    reg_idx_t                              idx;
    logic                                  wr_en;

    assign idx    = paddr[ADDR_BITS-1:ADDR_BITS-IDX_BITS];
    assign wr_en  = psel && penable && pwrite;
    assign pready = 1'b1;
    assign planes = plane_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            plane_reg <= '0;
        end
        else if (wr_en && (idx <= LAST_PLANE_IDX))
        begin
            plane_reg[idx] <= pwdata;
        end
    end

    always_comb
    begin
        prdata = '0;
        if (idx <= LAST_PLANE_IDX)
        begin
            prdata = plane_reg[idx];
        end
    end

endmodule

// ----- hdl/fcc_cell.sv -----
// ---------------------------------------------------------------------------
// fcc_cell
// One plane of the chain. Three stages: products, center value and corner
// spread, then the corner-range test folded into the item's verdict.
// ---------------------------------------------------------------------------
module fcc_cell
    import fcc_pkg::*;
(
    input  logic                  clk,
    input  logic                  rst_n,
    input  logic                  adv,
    input  logic [PLANE_BITS-1:0] plane,
    input  logic                  up_valid,
    input  cube_t                 up,
    output logic                  down_valid,
    output cube_t                 down
);

    logic signed [COEF_BITS-1:0]  coef_a;
    logic signed [COEF_BITS-1:0]  coef_b;
    logic signed [COEF_BITS-1:0]  coef_c;
    logic signed [COEF_BITS-1:0]  coef_d;
    logic signed [COORD_BITS-1:0] hs_s;

    logic                         v1_reg, v2_reg, v3_reg;
    cube_t                        c1_reg, c2_reg, c3_reg;
    logic signed [PROD_BITS-1:0]  pa_reg, pb_reg, pc_reg;
    logic signed [PROD_BITS-1:0]  qa_reg, qb_reg, qc_reg;
    logic signed [ACC_BITS-1:0]   s0_reg, m_reg;
    logic signed [ACC_BITS-1:0]   s0_next, m_next;
    logic signed [ACC_BITS-1:0]   hi_val, lo_val;
    cube_t                        c3_next;

    assign coef_a = plane[COEF_BITS-1:0];
    assign coef_b = plane[2*COEF_BITS-1:COEF_BITS];
    assign coef_c = plane[3*COEF_BITS-1:2*COEF_BITS];
    assign coef_d = plane[4*COEF_BITS-1:3*COEF_BITS];
    assign hs_s   = {1'b0, up.hs};

    function automatic logic signed [ACC_BITS-1:0] mag(input logic signed [PROD_BITS-1:0] p);
        logic signed [ACC_BITS-1:0] w;
        w = ACC_BITS'(p);
        return (w < 0) ? -w : w;
    endfunction

    // center value and the largest spread the sign choices of the corners reach
    always_comb
    begin
        s0_next = ACC_BITS'(pa_reg) + ACC_BITS'(pb_reg) + ACC_BITS'(pc_reg)
                + (ACC_BITS'(coef_d) <<< D_SHIFT);
        m_next  = mag(qa_reg) + mag(qb_reg) + mag(qc_reg);
    end

    // best corner > 0: some corner in front; worst corner > 0: all in front
    always_comb
    begin
        hi_val            = s0_reg + m_reg;
        lo_val            = s0_reg - m_reg;
        c3_next           = c2_reg;
        c3_next.outside   = c2_reg.outside | !(hi_val > 0);
        c3_next.all_front = c2_reg.all_front & (lo_val > 0);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end
        else if (adv)
        begin
            v1_reg <= up_valid;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            c1_reg <= up;
            pa_reg <= coef_a * up.cx;
            pb_reg <= coef_b * up.cy;
            pc_reg <= coef_c * up.cz;
            qa_reg <= coef_a * hs_s;
            qb_reg <= coef_b * hs_s;
            qc_reg <= coef_c * hs_s;
            c2_reg <= c1_reg;
            s0_reg <= s0_next;
            m_reg  <= m_next;
            c3_reg <= c3_next;
        end
    end

    assign down_valid = v3_reg;
    assign down       = c3_reg;

endmodule

// ----- hdl/frustum_cube_classifier_core.sv -----
// ---------------------------------------------------------------------------
// frustum_cube_classifier_core
// Cube-versus-frustum classifier: one item per clock unless stalled.
// An item enters every cycle the result side is not holding a stalled result.
// It passes down a chain of six plane cells, three stages each, with six
// 16x16 multipliers per cell, then an output register. Planes are written
// over APB at byte address 8*i (right, left, bottom, top, far, near);
// write them only while no item is in flight.
// ---------------------------------------------------------------------------
module frustum_cube_classifier_core
    import fcc_pkg::*;
(
    input  logic                         clk,
    input  logic                         rst_n,
    input  logic                         psel,
    input  logic                         penable,
    input  logic                         pwrite,
    input  logic [ADDR_BITS-1:0]         paddr,
    input  logic [PLANE_BITS-1:0]        pwdata,
    output logic [PLANE_BITS-1:0]        prdata,
    output logic                         pready,
    input  logic                         item_valid,
    output logic                         item_stall,
    input  logic signed [COORD_BITS-1:0] center_x,
    input  logic signed [COORD_BITS-1:0] center_y,
    input  logic signed [COORD_BITS-1:0] center_z,
    input  logic [HALF_BITS-1:0]         half_size,
    output logic                         result_valid,
    input  logic                         result_stall,
    output vis_t                         visibility
);

    logic [NUM_PLANES-1:0][PLANE_BITS-1:0] planes;
    logic [NUM_PLANES:0]                   chain_valid;
    cube_t [NUM_PLANES:0]                  chain;
    logic                                  adv;
    logic                                  out_valid_reg;
    vis_t                                  vis_reg;

    fcc_regs u_regs (
        .clk     (clk),
        .rst_n   (rst_n),
        .psel    (psel),
        .penable (penable),
        .pwrite  (pwrite),
        .paddr   (paddr),
        .pwdata  (pwdata),
        .prdata  (prdata),
        .pready  (pready),
        .planes  (planes)
    );

    // whole chain moves unless a finished result sits stalled
    assign adv        = !(out_valid_reg && result_stall);
    assign item_stall = !adv;

    always_comb
    begin
        chain_valid[0]     = item_valid;
        chain[0].cx        = center_x;
        chain[0].cy        = center_y;
        chain[0].cz        = center_z;
        chain[0].hs        = half_size;
        chain[0].outside   = 1'b0;
        chain[0].all_front = 1'b1;
    end

    for (genvar i = 0; i < NUM_PLANES; i++)
    begin : g_cell
        fcc_cell u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .adv        (adv),
            .plane      (planes[i]),
            .up_valid   (chain_valid[i]),
            .up         (chain[i]),
            .down_valid (chain_valid[i+1]),
            .down       (chain[i+1])
        );
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else if (adv)
        begin
            out_valid_reg <= chain_valid[NUM_PLANES];
        end
    end

    always_ff @(posedge clk)
    begin
        if (adv)
        begin
            vis_reg <= classify(chain[NUM_PLANES].outside, chain[NUM_PLANES].all_front);
        end
    end

    assign result_valid = out_valid_reg;
    assign visibility   = vis_reg;

endmodule

// ----- hdl/fcc_checker.sv -----
// ---------------------------------------------------------------------------
// fcc_checker
// Port-level checks on the classifier: result code range, stall coupling
// between the channels and a held result under stall.
// ---------------------------------------------------------------------------
module fcc_checker
    import fcc_pkg::*;
(
    input logic clk,
    input logic rst_n,
    input logic item_stall,
    input logic result_valid,
    input logic result_stall,
    input vis_t visibility
);

    // code 3 never comes out
    a_vis_range: assert property (@(posedge clk) disable iff (!rst_n)
        result_valid |-> (visibility != VIS_UNUSED))
        else $error("visibility code 3 on a valid result");

    // input only backs up behind a stalled result
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        item_stall |-> (result_valid && result_stall))
        else $error("item stalled without a stalled result");

    // a free output never holds back the input
    a_no_false_stall: assert property (@(posedge clk) disable iff (!rst_n)
        !result_valid |-> !item_stall)
        else $error("item stalled while output register empty");

    // stalled result holds
    a_hold: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && result_stall) |=> (result_valid && $stable(visibility)))
        else $error("stalled result changed");

endmodule

bind frustum_cube_classifier_core fcc_checker u_fcc_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .item_stall   (item_stall),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .visibility   (visibility)
);

// ----- tb/frustum_cube_classifier_core_tb.sv -----
`timescale 1ns / 1ps
// ---------------------------------------------------------------------------
// frustum_cube_classifier_core_tb
// Self-checking bench for the cube-versus-frustum classifier. Plane sets are
// loaded over APB while the pipe is empty. Cube queries are streamed through
// with random sender gaps and receiver stalls. Every visibility code is
// checked in order against a local model of the six plane tests.
// ---------------------------------------------------------------------------
module frustum_cube_classifier_core_tb;
    import fcc_pkg::*;

    localparam int CYCLE_LIMIT   = 400000;
    localparam int RANDOM_PHASES = 12;
    localparam int PHASE_ITEMS   = 125;
    localparam int DRAIN_CYCLES  = 40;
    localparam int NUM_CORNERS   = 8;
    localparam int REG_STRIDE    = PLANE_BITS / 8;
    localparam int ONE_COEF      = 1 << D_SHIFT;   // 1.0 in the normal format
    localparam int BOX_EXTENT    = 1600;           // 100.0 world units

    localparam logic [COEF_BITS-1:0] COEF_MAX = {1'b0, {(COEF_BITS-1){1'b1}}};
    localparam logic [COEF_BITS-1:0] COEF_MIN = {1'b1, {(COEF_BITS-1){1'b0}}};

    typedef enum int unsigned {
        REG_RIGHT, REG_LEFT, REG_BOTTOM, REG_TOP, REG_FAR, REG_NEAR, REG_SPARE6, REG_SPARE7
    } plane_reg_e;

    // RAW..ZERO must stay consecutive, the phase loop steps through them
    typedef enum int unsigned { SET_BOX, SET_RAW, SET_MAX, SET_MIN, SET_ZERO } plane_set_e;

    typedef enum int unsigned { IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH } idle_mode_e;

    typedef struct packed {
        logic signed [COORD_BITS-1:0] cx;
        logic signed [COORD_BITS-1:0] cy;
        logic signed [COORD_BITS-1:0] cz;
        logic        [HALF_BITS-1:0]  hs;
    } cube_query_t;

    logic                  clk;
    logic                  rst_n        = 1'b0;
    logic                  psel         = 1'b0;
    logic                  penable      = 1'b0;
    logic                  pwrite       = 1'b0;
    logic [ADDR_BITS-1:0]  paddr        = '0;
    logic [PLANE_BITS-1:0] pwdata       = '0;
    logic [PLANE_BITS-1:0] prdata;
    logic                  pready;
    logic                  item_valid   = 1'b0;
    logic                  item_stall;
    cube_query_t           on_bus       = '0;
    logic                  result_valid;
    logic                  result_stall = 1'b0;
    vis_t                  visibility;

    logic [PLANE_BITS-1:0] plane_regs [NUM_PLANES] = '{default: '0};
    cube_query_t           pending_cubes [$];
    vis_t                  expected_vis [$];
    cube_query_t           drive_cube;
    vis_t                  want;

    int sender_idle_pct    = 0;
    int receiver_stall_pct = 0;
    int queued_count       = 0;
    int results_seen       = 0;
    int error_count        = 0;
    int setting_count      = 0;
    int cycle_count        = 0;
    int class_count [4]    = '{default: 0};

    frustum_cube_classifier_core u_top (
        .clk          (clk),
        .rst_n        (rst_n),
        .psel         (psel),
        .penable      (penable),
        .pwrite       (pwrite),
        .paddr        (paddr),
        .pwdata       (pwdata),
        .prdata       (prdata),
        .pready       (pready),
        .item_valid   (item_valid),
        .item_stall   (item_stall),
        .center_x     (on_bus.cx),
        .center_y     (on_bus.cy),
        .center_z     (on_bus.cz),
        .half_size    (on_bus.hs),
        .result_valid (result_valid),
        .result_stall (result_stall),
        .visibility   (visibility)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    // exact plane sums at 64 bits; a sum of zero is not in front
    function automatic vis_t predict_visibility(input cube_query_t q);
        longint cx, cy, cz, hs, a, b, c, d, x, y, z, plane_sum;
        int     p, k, front, full_planes;
        logic   outside;
        cx = longint'($signed(q.cx));
        cy = longint'($signed(q.cy));
        cz = longint'($signed(q.cz));
        hs = longint'(q.hs);
        outside = 1'b0;
        full_planes = 0;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            a = longint'($signed(plane_regs[p][0*COEF_BITS +: COEF_BITS]));
            b = longint'($signed(plane_regs[p][1*COEF_BITS +: COEF_BITS]));
            c = longint'($signed(plane_regs[p][2*COEF_BITS +: COEF_BITS]));
            d = longint'($signed(plane_regs[p][3*COEF_BITS +: COEF_BITS])) <<< D_SHIFT;
            front = 0;
            for (k = 0; k < NUM_CORNERS; k++)
            begin
                x = (k & 1) ? cx + hs : cx - hs;
                y = (k & 2) ? cy + hs : cy - hs;
                z = (k & 4) ? cz + hs : cz - hs;
                plane_sum = a * x + b * y + c * z + d;
                if (plane_sum > 0)
                begin
                    front++;
                end
            end
            if (front == 0)
            begin
                outside = 1'b1;
            end
            if (front == NUM_CORNERS)
            begin
                full_planes++;
            end
        end
        if (outside)
        begin
            return VIS_OUTSIDE;
        end
        else if (full_planes == NUM_PLANES)
        begin
            return VIS_INSIDE;
        end
        return VIS_PARTIAL;
    endfunction

    function automatic cube_query_t random_cube();
        cube_query_t q;
        if ($urandom_range(99) < 70)
        begin
            // mostly near the origin where the planes sit
            q.cx = COORD_BITS'(int'($urandom_range(40000)) - 20000);
            q.cy = COORD_BITS'(int'($urandom_range(40000)) - 20000);
            q.cz = COORD_BITS'(int'($urandom_range(40000)) - 20000);
            case ($urandom_range(9))
                0:       q.hs = '0;
                1:       q.hs = HALF_BITS'($urandom());
                default: q.hs = HALF_BITS'($urandom_range(3000));
            endcase
        end
        else
        begin
            q.cx = COORD_BITS'($urandom());
            q.cy = COORD_BITS'($urandom());
            q.cz = COORD_BITS'($urandom());
            q.hs = HALF_BITS'($urandom());
        end
        return q;
    endfunction

    // axis-aligned face with random tilt; origin side is in front for offset > 0
    function automatic logic [PLANE_BITS-1:0] box_plane(input int p, input int tilt,
                                                         input int offset);
        int coef [3];
        int axis;
        for (axis = 0; axis < 3; axis++)
        begin
            coef[axis] = int'($urandom_range(2 * tilt)) - tilt;
        end
        // right, top and far face toward negative x, y and z
        coef[p / 2] = (p == REG_RIGHT || p == REG_TOP || p == REG_FAR) ? -ONE_COEF : ONE_COEF;
        return {COEF_BITS'(offset), COEF_BITS'(coef[2]), COEF_BITS'(coef[1]),
                COEF_BITS'(coef[0])};
    endfunction

    task automatic write_reg(input plane_reg_e idx, input logic [PLANE_BITS-1:0] value);
        @(posedge clk);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= ADDR_BITS'(idx * REG_STRIDE);
        pwdata  <= value;
        @(posedge clk);
        penable <= 1'b1;
        do
            @(posedge clk);
        while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        pwrite  <= 1'b0;
        if (idx < NUM_PLANES)
        begin
            plane_regs[idx] = value;
        end
    endtask

    task automatic load_planes(input plane_set_e kind);
        logic [PLANE_BITS-1:0] value;
        int                    p;
        for (p = 0; p < NUM_PLANES; p++)
        begin
            case (kind)
                SET_BOX: value = box_plane(p, ($urandom_range(3) == 0) ? 0 : 3000,
                                           int'($urandom_range(20000)) - 1000);
                SET_RAW: value = {$urandom(), $urandom()};
                SET_MAX: value = {4{COEF_MAX}};
                SET_MIN: value = {4{COEF_MIN}};
                default: value = '0;
            endcase
            write_reg(plane_reg_e'(p), value);
        end
        // slots past the near plane must not disturb anything
        write_reg(REG_SPARE6, {$urandom(), $urandom()});
        write_reg(REG_SPARE7, {$urandom(), $urandom()});
        setting_count++;
    endtask

    task automatic queue_cube(input cube_query_t q);
        pending_cubes.push_back(q);
        queued_count++;
    endtask

    // sender holds off until every queued item has come back
    task automatic wait_idle();
        do
            @(posedge clk);
        while (results_seen < queued_count);
    endtask

    // driver
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            item_valid <= 1'b0;
        end
        else
        begin
            if (item_valid && !item_stall)
            begin
                expected_vis.push_back(predict_visibility(on_bus));
            end
            if (!item_valid || !item_stall)
            begin
                if (pending_cubes.size() != 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    drive_cube = pending_cubes.pop_front();
                    on_bus     <= drive_cube;
                    item_valid <= 1'b1;
                end
                else
                begin
                    item_valid <= 1'b0;
                end
            end
        end
    end

    // monitor
    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            result_stall <= 1'b0;
        end
        else
        begin
            if (result_valid && !result_stall)
            begin
                results_seen++;
                if (expected_vis.size() == 0)
                begin
                    $display("%0t: result with nothing pending: expected none, actual %0d",
                             $time, visibility);
                    error_count++;
                end
                else
                begin
                    want = expected_vis.pop_front();
                    class_count[want]++;
                    if (visibility !== want)
                    begin
                        $display("%0t: visibility mismatch: expected %0d, actual %0d",
                                 $time, want, visibility);
                        error_count++;
                    end
                end
            end
            result_stall <= ($urandom_range(99) < receiver_stall_pct);
        end
    end

    always @(posedge clk)
    begin
        cycle_count++;
        if (cycle_count == CYCLE_LIMIT)
        begin
            $display("%0t: timeout after %0d cycles, %0d items outstanding",
                     $time, cycle_count, queued_count - results_seen);
            $display("Simulation FAILED");
            $finish;
        end
    end

    initial
    begin
        int         k, n, p;
        idle_mode_e mode;
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;

        // planes after reset are all zero: nothing in front
        queue_cube('{0, 0, 0, 0});
        queue_cube('{32767, 32767, 32767, 32767});
        wait_idle();

        // exact box of +-100 units, no tilt
        for (p = 0; p < NUM_PLANES; p++)
        begin
            write_reg(plane_reg_e'(p), box_plane(p, 0, BOX_EXTENT));
        end
        setting_count++;
        queue_cube('{0, 0, 0, 0});
        queue_cube('{BOX_EXTENT, 0, 0, 0});          // point on the right face
        queue_cube('{BOX_EXTENT - 1, 0, 0, 0});
        queue_cube('{0, 0, -BOX_EXTENT, 0});         // point on the near face
        queue_cube('{0, 0, 0, 100});
        queue_cube('{0, 0, 0, BOX_EXTENT});          // corners land on the faces
        queue_cube('{0, 0, 0, 32767});
        queue_cube('{1500, 1500, 1500, 200});
        queue_cube('{5000, 0, 0, 100});
        queue_cube('{32767, 32767, 32767, 32767});
        queue_cube('{-32768, -32768, -32768, 32767});
        queue_cube('{32767, -32768, 32767, 0});
        queue_cube('{-32768, 0, 0, 0});
        wait_idle();

        // largest and most negative coefficients against extreme cubes
        load_planes(SET_MAX);
        queue_cube('{32767, 32767, 32767, 32767});
        queue_cube('{-32768, -32768, -32768, 32767});
        queue_cube('{0, 0, 0, 0});
        wait_idle();
        load_planes(SET_MIN);
        queue_cube('{32767, 32767, 32767, 32767});
        queue_cube('{-32768, -32768, -32768, 32767});
        queue_cube('{0, 0, 0, 0});
        wait_idle();

        for (k = 0; k < RANDOM_PHASES; k++)
        begin
            if (k % 3 == 2)
            begin
                load_planes(plane_set_e'(SET_RAW + (k / 3) % 4));
            end
            else
            begin
                load_planes(SET_BOX);
            end
            mode = idle_mode_e'(k % 4);
            sender_idle_pct    = (mode == IDLE_SENDER)   ? 58 : (mode == IDLE_BOTH) ? 11 : 0;
            receiver_stall_pct = (mode == IDLE_RECEIVER) ? 58 : (mode == IDLE_BOTH) ? 11 : 0;
            for (n = 0; n < PHASE_ITEMS; n++)
            begin
                queue_cube(random_cube());
            end
            wait_idle();
        end

        repeat (DRAIN_CYCLES) @(posedge clk);
        $display("Ran %0d cube queries through %0d plane settings and four idle patterns",
                 results_seen, setting_count);
        $display("Outcomes seen: %0d outside, %0d partial, %0d inside, %0d errors",
                 class_count[VIS_OUTSIDE], class_count[VIS_PARTIAL], class_count[VIS_INSIDE],
                 error_count);
        if (error_count == 0 && expected_vis.size() == 0)
        begin
            $display("Simulation PASSED");
        end
        else
        begin
            $display("Simulation FAILED");
        end
        $finish;
    end

endmodule

// ----- files.f -----
hdl/fcc_pkg.sv
hdl/fcc_regs.sv
hdl/fcc_cell.sv
hdl/frustum_cube_classifier_core.sv
hdl/fcc_checker.sv
tb/frustum_cube_classifier_core_tb.sv
